[src/dual_distance_posture_qualifier_defines.svh]
// assertion macros shared by the posture qualifier rtl
`ifndef DUAL_DISTANCE_POSTURE_QUALIFIER_DEFINES_SVH
`define DUAL_DISTANCE_POSTURE_QUALIFIER_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define DDPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is held
`define DDPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/ddpq_pkg.sv]
// types, constants and register indexes of the posture qualifier
package ddpq_pkg;

	localparam int unsigned DIST_W  = 16;
	localparam int unsigned LIM_W   = 13;
	localparam int unsigned BAD_W   = 8;
	localparam int unsigned DEAD_W  = 6;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [DIST_W-1:0] DEAD_CODE_LOW = 16'd8190;
	localparam logic [DIST_W-1:0] DEAD_CODE_ALL = 16'hFFFF;
	localparam logic [DEAD_W-1:0] DEAD_RUN_CAP  = 6'd50;
	localparam logic [BAD_W-1:0]  BAD_RUN_CAP   = 8'd255;

	localparam logic [LIM_W-1:0]  MIN_DIST_RST  = 13'd30;
	localparam logic [LIM_W-1:0]  MAX_DIST_RST  = 13'd900;
	localparam logic [LIM_W-1:0]  GAP_LIMIT_RST = 13'd80;
	localparam logic [BAD_W-1:0]  BAD_LIMIT_RST = 8'd25;
	localparam logic [DEAD_W-1:0] DEAD_LIMIT_RST = 6'd25;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_DISTANCE = 3'd0,
		REG_MAX_DISTANCE = 3'd1,
		REG_GAP_LIMIT    = 3'd2,
		REG_BAD_LIMIT    = 3'd3,
		REG_DEAD_LIMIT   = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		VIB_EV_NONE = 2'd0,
		VIB_EV_ON   = 2'd1,
		VIB_EV_OFF  = 2'd2
	} vib_event_t;

	typedef struct packed {
		logic [DIST_W-1:0] dist_middle;
		logic [DIST_W-1:0] dist_right;
	} in_word_t;

	typedef struct packed {
		logic              middle_valid;
		logic              right_valid;
		logic [DIST_W-1:0] distance_gap;
		logic              posture_good;
		logic              vibrate_active;
		logic [1:0]        vibrate_event;
		logic              reinit_request;
	} out_word_t;

	typedef struct packed {
		logic dead;
		logic ok;
	} reading_stat_t;

endpackage

[src/ddpq_in_if.sv]
// input channel: one word carries both distance readings
interface ddpq_in_if;
	import ddpq_pkg::*;

	logic     valid;
	logic     ready;
	in_word_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[src/ddpq_out_if.sv]
// result channel: one word per sample pair
interface ddpq_out_if;
	import ddpq_pkg::*;

	logic      valid;
	logic      ready;
	out_word_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[src/ddpq_reading_check.sv]
// dead-code and range check of one distance reading
module ddpq_reading_check (
	input  logic [ddpq_pkg::DIST_W-1:0] reading,
	input  logic [ddpq_pkg::LIM_W-1:0]  min_distance,
	input  logic [ddpq_pkg::LIM_W-1:0]  max_distance,
	output ddpq_pkg::reading_stat_t     stat
);
	import ddpq_pkg::*;

	logic [DIST_W-1:0] min_ext;
	logic [DIST_W-1:0] max_ext;

	assign min_ext = {{(DIST_W-LIM_W){1'b0}}, min_distance};
	assign max_ext = {{(DIST_W-LIM_W){1'b0}}, max_distance};

	// all-ones is also above the low dead code, kept for clarity
	assign stat.dead = (reading == '0) || (reading == DEAD_CODE_ALL) ||
		(reading >= DEAD_CODE_LOW);
	assign stat.ok   = !stat.dead && (reading >= min_ext) && (reading <= max_ext);
endmodule

[src/dual_distance_posture_qualifier.sv]
// top level of the dual distance posture qualifier
//
// usage:
//   sample : valid/ready channel, one word holds dist_middle and dist_right
//   result : valid/ready channel, one word per accepted sample word
//   cfg    : write port (cfg_we, cfg_idx, cfg_wdata); index 0 min_distance,
//            1 max_distance, 2 gap_limit, 3 bad_limit, 4 dead_limit;
//            other indexes are dropped, data is cut to the register width
//   throughput: one word per cycle while result.ready is high, set by the
//            single registered pass from the input register through the compare and counter logic
//   path: a taken sample word loads into the input register, then into
//            the result register once that register is free
//   stall: when the result receiver holds ready low the result register
//            keeps its word; one more sample word can wait in the input
//            register, after which sample.ready drops
//   reset: arst_n clears both valid flags, the bad and dead runs and the
//            vibration flag, and loads the register defaults
//            (30, 900, 80, 25, 25)
//   the counters move only when a word passes into the result register,
//   so words see the state in arrival order
module dual_distance_posture_qualifier (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ddpq_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [ddpq_pkg::LIM_W-1:0]     cfg_wdata,
	ddpq_in_if.sink                        sample,
	ddpq_out_if.source                     result
);
	import ddpq_pkg::*;

	`include "dual_distance_posture_qualifier_defines.svh"

	// configuration registers
	logic [LIM_W-1:0]  min_dist_q;
	logic [LIM_W-1:0]  max_dist_q;
	logic [LIM_W-1:0]  gap_limit_q;
	logic [BAD_W-1:0]  bad_limit_q;
	logic [DEAD_W-1:0] dead_limit_q;

	// running state
	logic [BAD_W-1:0]  bad_run_q;
	logic              vib_flag_q;
	logic [DEAD_W-1:0] dead_run_q;

	// input register
	logic              valid_s1;
	in_word_t          word_s1;

	// result register
	logic              res_valid_q;
	out_word_t         res_q;

	logic              out_load;
	logic              advance;

	reading_stat_t     mid_stat;
	reading_stat_t     rgt_stat;

	logic [DEAD_W-1:0] dead_inc;
	logic              reinit_c;
	logic [DEAD_W-1:0] dead_next;
	logic [DIST_W-1:0] gap_c;
	logic              good_c;
	logic [BAD_W-1:0]  bad_inc;
	logic [BAD_W-1:0]  bad_next;
	logic              vib_next;
	vib_event_t        event_c;
	out_word_t         res_next;

	// handshake: the result register frees when empty or taken
	assign out_load     = !res_valid_q || result.ready;
	assign advance      = valid_s1 && out_load;
	assign sample.ready = !valid_s1 || out_load;
	assign result.valid = res_valid_q;
	assign result.payload = res_q;

	// register writes; the user must write only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_dist_q   <= MIN_DIST_RST;
			max_dist_q   <= MAX_DIST_RST;
			gap_limit_q  <= GAP_LIMIT_RST;
			bad_limit_q  <= BAD_LIMIT_RST;
			dead_limit_q <= DEAD_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_MIN_DISTANCE: min_dist_q   <= cfg_wdata;
				REG_MAX_DISTANCE: max_dist_q   <= cfg_wdata;
				REG_GAP_LIMIT:    gap_limit_q  <= cfg_wdata;
				REG_BAD_LIMIT:    bad_limit_q  <= cfg_wdata[BAD_W-1:0];
				REG_DEAD_LIMIT:   dead_limit_q <= cfg_wdata[DEAD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			word_s1 <= sample.payload;
		end
	end

	// per-reading checks
	ddpq_reading_check u_chk_mid (
		.reading      (word_s1.dist_middle),
		.min_distance (min_dist_q),
		.max_distance (max_dist_q),
		.stat         (mid_stat)
	);

	ddpq_reading_check u_chk_rgt (
		.reading      (word_s1.dist_right),
		.min_distance (min_dist_q),
		.max_distance (max_dist_q),
		.stat         (rgt_stat)
	);

	// dead run: counts both-dead words, saturates at the cap, reinit clears it
	always_comb begin
		if (mid_stat.dead && rgt_stat.dead) begin
			dead_inc = (dead_run_q < DEAD_RUN_CAP) ? dead_run_q + 1'b1 : dead_run_q;
		end else begin
			dead_inc = '0;
		end
		reinit_c  = (dead_inc >= dead_limit_q);
		dead_next = reinit_c ? '0 : dead_inc;
	end

	// gap and posture
	always_comb begin
		if (word_s1.dist_middle > word_s1.dist_right) begin
			gap_c = word_s1.dist_middle - word_s1.dist_right;
		end else begin
			gap_c = word_s1.dist_right - word_s1.dist_middle;
		end
		good_c = mid_stat.ok && rgt_stat.ok &&
			(gap_c <= {{(DIST_W-LIM_W){1'b0}}, gap_limit_q});
	end

	// bad run and vibration flag
	always_comb begin
		bad_inc  = (bad_run_q == BAD_RUN_CAP) ? bad_run_q : bad_run_q + 1'b1;
		bad_next = bad_inc;
		vib_next = vib_flag_q;
		event_c  = VIB_EV_NONE;
		if (good_c) begin
			bad_next = '0;
			vib_next = 1'b0;
			if (vib_flag_q) begin
				event_c = VIB_EV_OFF;
			end
		end else if (!vib_flag_q && (bad_inc >= bad_limit_q)) begin
			vib_next = 1'b1;
			event_c  = VIB_EV_ON;
		end
	end

	always_comb begin
		res_next.middle_valid   = mid_stat.ok;
		res_next.right_valid    = rgt_stat.ok;
		res_next.distance_gap   = gap_c;
		res_next.posture_good   = good_c;
		res_next.vibrate_active = vib_next;
		res_next.vibrate_event  = event_c;
		res_next.reinit_request = reinit_c;
	end

	// state moves with the word entering the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bad_run_q  <= '0;
			vib_flag_q <= 1'b0;
			dead_run_q <= '0;
		end else if (advance) begin
			bad_run_q  <= bad_next;
			vib_flag_q <= vib_next;
			dead_run_q <= dead_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	// checks on the run counters and the flag
	`DDPQ_ASSERT_IMP(a_dead_cap, clk, arst_n, 1'b1, dead_run_q <= DEAD_RUN_CAP, "dead run above cap")
	`DDPQ_ASSERT_NXT(a_reinit_clear, clk, arst_n, advance && reinit_c, dead_run_q == '0, "dead run not cleared by reinit")
	`DDPQ_ASSERT_NXT(a_good_clear, clk, arst_n, advance && good_c, (bad_run_q == '0) && !vib_flag_q, "good word did not clear bad run and flag")
	`DDPQ_ASSERT_NXT(a_hold_state, clk, arst_n, !advance, $stable(bad_run_q) && $stable(vib_flag_q) && $stable(dead_run_q), "state moved without a word")
endmodule
